// File: hw/rtl/bse_pkg.sv
// Shared types and constants for the 3x3 binary spur erosion block.
`default_nettype none

package bse_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int MINN_W    = 4;
    localparam int WIDTH_W   = 11;
    localparam int ROW_W     = 12;
    localparam int NUM_REGS  = 4;
    localparam int APB_AW    = $clog2(4 * NUM_REGS);
    localparam int APB_DW    = 32;

    localparam logic [MINN_W-1:0]  RST_MIN_NEIGHBORS = MINN_W'(3);
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH   = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT  = ROW_W'(480);
    localparam logic               RST_ZERO_BORDER   = 1'b1;

    localparam logic [WIDTH_W-1:0] MIN_COLS = WIDTH_W'(3);
    localparam logic [ROW_W-1:0]   MIN_ROWS = ROW_W'(3);
    localparam logic [COL_W-1:0]   MIN_WM1  = COL_W'(2);
    localparam logic [COL_W-1:0]   MAX_WM1  = COL_W'(MAX_WIDTH - 1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [APB_AW-3:0] {
        REG_MIN_NEIGHBORS = 2'd0,
        REG_IMAGE_WIDTH   = 2'd1,
        REG_IMAGE_HEIGHT  = 2'd2,
        REG_ZERO_BORDER   = 2'd3
    } t_reg_idx;

    // Effective geometry and thresholds as seen by the datapath
    typedef struct packed {
        logic [MINN_W-1:0] min_neighbors;
        logic              zero_border;
        logic [COL_W-1:0]  wm1;
        logic [ROW_W-1:0]  h;
        logic [ROW_W-1:0]  hm1;
    } t_cfg;

    // Control for the item held in the window stage
    typedef struct packed {
        logic             emit;
        logic             border;
        logic             last;
        logic [COL_W-1:0] p_col;
    } t_slot;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_lb_req;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] col;
        logic             val;
    } t_flag_wr;

endpackage

`default_nettype wire

// File: hw/rtl/binary_spur_erosion_3x3_core.sv
// Top level of the 3x3 binary spur erosion block.
//
// Streams an 8-bit frame in raster order and takes one item per clock,
// pixel or drain, with no bubbles unless the output stalls: each item
// reads one column of the input-row store and the flag-row store through
// their single read ports and moves through one window stage into the
// output register. The result for a pixel appears once the pixel one row
// and one column further on is in, so a frame needs image_width+1 drain
// items after its last pixel; the drain result with frame_last set ends
// the frame. Result valid comes from the output register, behind the
// window stage. Writing width or height restarts the frame; configure only while idle.
`default_nettype none

module binary_spur_erosion_3x3_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bse_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bse_pkg::APB_DW-1:0]  pwdata,
    output logic      [bse_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_op,
    input  wire logic [bse_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [bse_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                             o_frame_last
);

    bse_pkg::t_cfg             cfg;
    logic                      restart;
    logic                      out_free;
    logic                      s1_move;
    bse_pkg::t_slot            slot;
    logic [bse_pkg::PIX_W-1:0] s1_pix;
    bse_pkg::t_lb_req          lb_req;
    bse_pkg::t_flag_wr         flag_wr;
    logic [bse_pkg::PIX_W-1:0] rd_pix;
    logic                      rd_flag;

    bse_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    bse_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_restart  (restart),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_pixel_in (i_pixel_in),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_s1_move  (s1_move),
        .o_slot     (slot),
        .o_s1_pix   (s1_pix),
        .o_lb_req   (lb_req)
    );

    bse_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_lb_req  (lb_req),
        .i_flag_wr (flag_wr),
        .o_rd_pix  (rd_pix),
        .o_rd_flag (rd_flag)
    );

    bse_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s1_move    (s1_move),
        .i_slot       (slot),
        .i_s1_pix     (s1_pix),
        .i_rd_pix     (rd_pix),
        .i_rd_flag    (rd_flag),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .o_out_free   (out_free),
        .o_flag_wr    (flag_wr)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bse_cfg.sv
// APB register file with effective frame geometry.
`default_nettype none

module bse_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bse_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bse_pkg::APB_DW-1:0]   pwdata,
    output logic      [bse_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output bse_pkg::t_cfg                     o_cfg,
    output logic                              o_restart
);

    function automatic logic [bse_pkg::COL_W-1:0] wm1_of(
        input logic [bse_pkg::WIDTH_W-1:0] raw
    );
        logic [31:0]                 dec;
        logic [bse_pkg::COL_W-1:0]   res;
        dec = 32'(raw) - 32'd1;
        if (raw < bse_pkg::MIN_COLS) begin
            res = bse_pkg::MIN_WM1;
        end else if (32'(raw) > 32'(bse_pkg::MAX_WIDTH)) begin
            res = bse_pkg::MAX_WM1;
        end else begin
            res = dec[bse_pkg::COL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [bse_pkg::ROW_W-1:0] h_of(
        input logic [bse_pkg::ROW_W-1:0] raw
    );
        logic [bse_pkg::ROW_W-1:0] res;
        res = (raw < bse_pkg::MIN_ROWS) ? bse_pkg::MIN_ROWS : raw;
        return res;
    endfunction

    logic [bse_pkg::MINN_W-1:0]  r_min_neighbors;
    logic [bse_pkg::WIDTH_W-1:0] r_image_width;
    logic [bse_pkg::ROW_W-1:0]   r_image_height;
    logic                        r_zero_border;
    logic [bse_pkg::COL_W-1:0]   r_wm1;
    logic [bse_pkg::ROW_W-1:0]   r_h;
    logic [bse_pkg::ROW_W-1:0]   r_hm1;

    logic                        wr;
    bse_pkg::t_reg_idx           idx;
    logic [bse_pkg::WIDTH_W-1:0] wr_width;
    logic [bse_pkg::ROW_W-1:0]   wr_height;
    logic [bse_pkg::ROW_W-1:0]   wr_h;

    assign pready    = 1'b1;
    assign wr        = psel && penable && pwrite && pready;
    assign idx       = bse_pkg::t_reg_idx'(paddr[bse_pkg::APB_AW-1:2]);
    assign wr_width  = pwdata[bse_pkg::WIDTH_W-1:0];
    assign wr_height = pwdata[bse_pkg::ROW_W-1:0];
    assign wr_h      = h_of(wr_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_neighbors <= bse_pkg::RST_MIN_NEIGHBORS;
            r_image_width   <= bse_pkg::RST_IMAGE_WIDTH;
            r_image_height  <= bse_pkg::RST_IMAGE_HEIGHT;
            r_zero_border   <= bse_pkg::RST_ZERO_BORDER;
            r_wm1           <= wm1_of(bse_pkg::RST_IMAGE_WIDTH);
            r_h             <= h_of(bse_pkg::RST_IMAGE_HEIGHT);
            r_hm1           <= h_of(bse_pkg::RST_IMAGE_HEIGHT) - 1'b1;
        end else if (wr) begin
            unique case (idx)
                bse_pkg::REG_MIN_NEIGHBORS: begin
                    r_min_neighbors <= pwdata[bse_pkg::MINN_W-1:0];
                end
                bse_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= wr_width;
                    r_wm1         <= wm1_of(wr_width);
                end
                bse_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= wr_height;
                    r_h            <= wr_h;
                    r_hm1          <= wr_h - 1'b1;
                end
                bse_pkg::REG_ZERO_BORDER: begin
                    r_zero_border <= pwdata[0];
                end
                default: begin
                    r_zero_border <= r_zero_border;
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bse_pkg::REG_MIN_NEIGHBORS:
                prdata = {{(bse_pkg::APB_DW-bse_pkg::MINN_W){1'b0}}, r_min_neighbors};
            bse_pkg::REG_IMAGE_WIDTH:
                prdata = {{(bse_pkg::APB_DW-bse_pkg::WIDTH_W){1'b0}}, r_image_width};
            bse_pkg::REG_IMAGE_HEIGHT:
                prdata = {{(bse_pkg::APB_DW-bse_pkg::ROW_W){1'b0}}, r_image_height};
            bse_pkg::REG_ZERO_BORDER:
                prdata = {{(bse_pkg::APB_DW-1){1'b0}}, r_zero_border};
            default:
                prdata = '0;
        endcase
    end

    // Geometry writes abandon the frame in progress
    assign o_restart = wr && ((idx == bse_pkg::REG_IMAGE_WIDTH) ||
                              (idx == bse_pkg::REG_IMAGE_HEIGHT));

    assign o_cfg.min_neighbors = r_min_neighbors;
    assign o_cfg.zero_border   = r_zero_border;
    assign o_cfg.wm1           = r_wm1;
    assign o_cfg.h             = r_h;
    assign o_cfg.hm1           = r_hm1;

endmodule

`default_nettype wire

// File: hw/rtl/bse_seq.sv
// Raster sequencing: input acceptance, stream and output positions, window-stage control.
`default_nettype none

module bse_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bse_pkg::t_cfg               i_cfg,
    input  wire logic                        i_restart,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_op,
    input  wire logic [bse_pkg::PIX_W-1:0]   i_pixel_in,
    input  wire logic                        i_out_free,
    output logic                             o_in_ready,
    output logic                             o_s1_move,
    output bse_pkg::t_slot                   o_slot,
    output logic      [bse_pkg::PIX_W-1:0]   o_s1_pix,
    output bse_pkg::t_lb_req                 o_lb_req
);

    logic [bse_pkg::COL_W-1:0] r_s_col;
    logic [bse_pkg::ROW_W-1:0] r_in_row;
    logic [bse_pkg::COL_W-1:0] r_p_col;
    logic [bse_pkg::ROW_W-1:0] r_p_row;
    logic                      r_s1_valid;
    bse_pkg::t_slot            r_s1_slot;
    logic [bse_pkg::PIX_W-1:0] r_s1_pix;

    logic [bse_pkg::COL_W-1:0] n_s_col;
    logic [bse_pkg::ROW_W-1:0] n_in_row;
    logic [bse_pkg::COL_W-1:0] n_p_col;
    logic [bse_pkg::ROW_W-1:0] n_p_row;

    logic           s1_move;
    logic           s1_free;
    logic           accept;
    logic           is_drain;
    logic           in_done;
    logic           stream;
    logic           emit;
    logic           col_wrap;
    bse_pkg::t_slot slot;

    assign s1_move  = r_s1_valid && (!r_s1_slot.emit || i_out_free);
    assign s1_free  = !r_s1_valid || s1_move;
    assign accept   = i_in_valid && s1_free;
    assign is_drain = (i_op == bse_pkg::OP_DRAIN);
    assign in_done  = (r_in_row == i_cfg.h);
    // Pixels once the frame is in, and drains before it is, are dropped
    assign stream   = accept && (is_drain ? in_done : !in_done);
    // Output trails the stream by one row and one pixel
    assign emit     = (r_in_row[bse_pkg::ROW_W-1:1] != '0) ||
                      (r_in_row[0] && (r_s_col != '0));
    assign col_wrap = (r_s_col == i_cfg.wm1);

    assign slot.emit   = emit;
    assign slot.p_col  = r_p_col;
    assign slot.border = (r_p_row == '0) || (r_p_col == '0) ||
                         (r_p_row == i_cfg.hm1) || (r_p_col == i_cfg.wm1);
    assign slot.last   = (r_p_row == i_cfg.hm1) && (r_p_col == i_cfg.wm1);

    always_comb begin
        n_s_col  = r_s_col;
        n_in_row = r_in_row;
        n_p_col  = r_p_col;
        n_p_row  = r_p_row;
        if (i_restart || (stream && emit && slot.last)) begin
            n_s_col  = '0;
            n_in_row = '0;
            n_p_col  = '0;
            n_p_row  = '0;
        end else if (stream) begin
            n_s_col = col_wrap ? '0 : r_s_col + 1'b1;
            if (!is_drain && col_wrap) begin
                n_in_row = r_in_row + 1'b1;
            end
            if (emit) begin
                if (r_p_col == i_cfg.wm1) begin
                    n_p_col = '0;
                    n_p_row = r_p_row + 1'b1;
                end else begin
                    n_p_col = r_p_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_col    <= '0;
            r_in_row   <= '0;
            r_p_col    <= '0;
            r_p_row    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s_col  <= n_s_col;
            r_in_row <= n_in_row;
            r_p_col  <= n_p_col;
            r_p_row  <= n_p_row;
            if (stream) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stream) begin
            r_s1_slot <= slot;
            r_s1_pix  <= is_drain ? '0 : i_pixel_in;
        end
    end

    assign o_in_ready   = s1_free;
    assign o_s1_move    = s1_move;
    assign o_slot       = r_s1_slot;
    assign o_s1_pix     = r_s1_pix;
    assign o_lb_req.en  = stream;
    assign o_lb_req.col = r_s_col;
    assign o_lb_req.pix = is_drain ? '0 : i_pixel_in;

    a_last_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_slot.last |-> r_s1_slot.emit && r_s1_slot.border)
        else $error("frame end item not an emitting border item");

    a_frame_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stream && emit && slot.last |=>
            (r_in_row == '0) && (r_s_col == '0) && (r_p_row == '0) && (r_p_col == '0))
        else $error("counters not cleared after frame end");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= i_cfg.h)
        else $error("input row beyond frame height");

endmodule

`default_nettype wire

// File: hw/rtl/bse_linebuf.sv
// Row stores: one row of input pixels and one row of processed white flags.
`default_nettype none

module bse_linebuf (
    input  wire logic                        i_clk,
    input  wire bse_pkg::t_lb_req            i_lb_req,
    input  wire bse_pkg::t_flag_wr           i_flag_wr,
    output logic      [bse_pkg::PIX_W-1:0]   o_rd_pix,
    output logic                             o_rd_flag
);

    logic [bse_pkg::PIX_W-1:0] r_pix_mem  [bse_pkg::MAX_WIDTH];
    logic                      r_flag_mem [bse_pkg::MAX_WIDTH];
    logic [bse_pkg::PIX_W-1:0] r_rd_pix;
    logic                      r_rd_flag;

    // Read returns the previous row at this column, then the new pixel replaces it
    always_ff @(posedge i_clk) begin
        if (i_lb_req.en) begin
            r_rd_pix                 <= r_pix_mem[i_lb_req.col];
            r_pix_mem[i_lb_req.col]  <= i_lb_req.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lb_req.en) begin
            r_rd_flag <= r_flag_mem[i_lb_req.col];
        end
        if (i_flag_wr.en) begin
            r_flag_mem[i_flag_wr.col] <= i_flag_wr.val;
        end
    end

    assign o_rd_pix  = r_rd_pix;
    assign o_rd_flag = r_rd_flag;

endmodule

`default_nettype wire

// File: hw/rtl/bse_window.sv
// 3x3 window taps, neighbour count, clear decision and output register.
`default_nettype none

module bse_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bse_pkg::t_cfg               i_cfg,
    input  wire logic                        i_s1_move,
    input  wire bse_pkg::t_slot              i_slot,
    input  wire logic [bse_pkg::PIX_W-1:0]   i_s1_pix,
    input  wire logic [bse_pkg::PIX_W-1:0]   i_rd_pix,
    input  wire logic                        i_rd_flag,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic      [bse_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                             o_frame_last,
    output logic                             o_out_free,
    output bse_pkg::t_flag_wr                o_flag_wr
);

    logic [bse_pkg::PIX_W-1:0] r_x1;
    logic [bse_pkg::PIX_W-1:0] r_x2;
    logic [bse_pkg::PIX_W-1:0] r_u1;
    logic                      r_f1;
    logic                      r_f2;
    logic                      r_left;
    logic                      r_out_valid;
    logic [bse_pkg::PIX_W-1:0] r_out_pix;
    logic                      r_out_last;

    logic [bse_pkg::MINN_W-1:0] n_cnt;
    logic                       clear;
    logic [bse_pkg::PIX_W-1:0]  proc;
    logic [bse_pkg::PIX_W-1:0]  value;
    logic                       emit_now;
    logic                       out_free;

    // Upper row from processed flags, lower row and right neighbour from input
    assign n_cnt = {3'b0, i_rd_flag} + {3'b0, r_f1} + {3'b0, r_f2} + {3'b0, r_left} +
                   {3'b0, (i_rd_pix != '0)} + {3'b0, (i_s1_pix != '0)} +
                   {3'b0, (r_x1 != '0)} + {3'b0, (r_x2 != '0)};

    assign clear    = !i_slot.border && (r_u1 != '0) && (n_cnt < i_cfg.min_neighbors);
    assign proc     = clear ? '0 : r_u1;
    assign value    = (i_slot.border && i_cfg.zero_border) ? '0 : proc;
    assign emit_now = i_s1_move && i_slot.emit;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_s1_move) begin
            r_x2 <= r_x1;
            r_x1 <= i_s1_pix;
            r_u1 <= i_rd_pix;
            r_f2 <= r_f1;
            r_f1 <= i_rd_flag;
        end
        if (emit_now) begin
            r_left     <= (proc != '0);
            r_out_pix  <= value;
            r_out_last <= i_slot.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_now) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_out_pix;
    assign o_frame_last  = r_out_last;
    assign o_out_free    = out_free;
    assign o_flag_wr.en  = emit_now;
    assign o_flag_wr.col = i_slot.p_col;
    assign o_flag_wr.val = (proc != '0);

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_now |=> r_out_valid)
        else $error("emitted item did not reach the output register");

endmodule

`default_nettype wire
